@@ src/assert_macros.svh @@
// Assertion macros shared by the router RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, masked while rst is high.
`define SRR_ASSERT_IMPL(lbl, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, sampled on clk, masked while rst is high.
`define SRR_ASSERT_NEXT(lbl, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

@@ src/srr_pkg.sv @@
// Types and constants for the sticky round-robin partition router.
`timescale 1ns / 1ps

package srr_pkg;

  // Field widths
  localparam int unsigned DIVIDEND_W = 32;
  localparam int unsigned PART_CNT_W = 11;
  localparam int unsigned PART_W     = 10;
  localparam int unsigned HASH_W     = 31;
  localparam int unsigned LEN_W      = 24;
  localparam int unsigned TIME_W     = 48;
  localparam int unsigned MSGS_W     = 16;
  localparam int unsigned DELAY_W    = 16;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] REG_BATCHING_ENABLED   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_BATCH_MESSAGES = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_BATCH_BYTES    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_BATCH_DELAY_MS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_PARTITIONS     = 3'd4;

  // Largest partition count the count register can hold
  localparam int unsigned PART_CNT_MAX = (1 << PART_CNT_W) - 1;

  // Live configuration as seen by the batch tracker
  typedef struct packed {
    logic                  batching_enabled;
    logic [MSGS_W-1:0]     max_batch_messages;
    logic [LEN_W-1:0]      max_batch_bytes;
    logic [DELAY_W-1:0]    max_batch_delay_ms;
    logic [PART_CNT_W-1:0] n_eff;
  } cfg_t;

endpackage

@@ src/srr_div.sv @@
// Iterative radix-2 remainder unit: one compare and subtract per cycle.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module srr_div
  import srr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [PART_CNT_W-1:0] divisor,
  output logic                  busy,
  output logic                  done,
  output logic [PART_CNT_W-1:0] rem
);

  localparam int unsigned CNT_W = $clog2(DIVIDEND_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIVIDEND_W - 1);

  logic [DIVIDEND_W-1:0] quo;
  logic [PART_CNT_W-1:0] divisor_q;
  logic [CNT_W-1:0]      cnt;
  logic [PART_CNT_W:0]   trial;
  logic [PART_CNT_W-1:0] rem_next;

  // shift in the next dividend bit and subtract when it fits
  always_comb begin
    trial = {rem, quo[DIVIDEND_W-1]};
    if (trial >= {1'b0, divisor_q}) begin
      rem_next = PART_CNT_W'(trial - {1'b0, divisor_q});
    end else begin
      rem_next = trial[PART_CNT_W-1:0];
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      quo       <= dividend;
      divisor_q <= divisor;
      rem       <= '0;
    end else if (busy) begin
      quo <= {quo[DIVIDEND_W-2:0], 1'b0};
      rem <= rem_next;
    end
  end

  `SRR_ASSERT_IMPL(a_rem_below_divisor, done, rem < divisor_q)

endmodule

@@ src/srr_batch.sv @@
// Batch tracker: cursor, batch counters and the switch decision.
`timescale 1ns / 1ps

module srr_batch
  import srr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  accept,
  input  cfg_t                  cfg,
  input  logic                  has_key,
  input  logic [HASH_W-1:0]     key_hash,
  input  logic [LEN_W-1:0]      message_length,
  input  logic [TIME_W-1:0]     now_ms,
  output logic [DIVIDEND_W-1:0] dividend,
  output logic                  fresh
);

  logic [DIVIDEND_W-1:0] cursor, cursor_next;
  logic [TIME_W-1:0]     last_switch_ms, last_switch_ms_next;
  logic [MSGS_W-1:0]     batch_count, batch_count_next;
  logic [LEN_W-1:0]      batch_bytes, batch_bytes_next;

  logic [TIME_W-1:0] elapsed;
  logic [LEN_W:0]    bytes_sum;
  logic              single;
  logic              full;

  // limit checks
  always_comb begin
    elapsed   = now_ms - last_switch_ms;
    bytes_sum = {1'b0, batch_bytes} + {1'b0, message_length};
    single    = (cfg.n_eff == PART_CNT_W'(1));
    full      = (batch_count >= cfg.max_batch_messages) ||
                (bytes_sum >= {1'b0, cfg.max_batch_bytes}) ||
                (elapsed >= TIME_W'(cfg.max_batch_delay_ms));
  end

  // routing decision
  always_comb begin
    cursor_next         = cursor;
    last_switch_ms_next = last_switch_ms;
    batch_count_next    = batch_count;
    batch_bytes_next    = batch_bytes;
    fresh               = 1'b0;
    dividend            = cursor;
    if (single) begin
      dividend = '0;
    end else if (has_key) begin
      dividend = {1'b0, key_hash};
    end else if (!cfg.batching_enabled) begin
      cursor_next = cursor + 1'b1;
    end else if (full) begin
      cursor_next         = cursor + 1'b1;
      last_switch_ms_next = now_ms;
      batch_bytes_next    = message_length;
      batch_count_next    = MSGS_W'(1);
      fresh               = 1'b1;
      dividend            = cursor_next;
    end else begin
      batch_count_next = batch_count + 1'b1;
      batch_bytes_next = bytes_sum[LEN_W-1:0];
    end
  end

  // state update on each accepted request
  always_ff @(posedge clk) begin
    if (rst) begin
      cursor         <= '0;
      last_switch_ms <= '0;
      batch_count    <= '0;
      batch_bytes    <= '0;
    end else if (accept) begin
      cursor         <= cursor_next;
      last_switch_ms <= last_switch_ms_next;
      batch_count    <= batch_count_next;
      batch_bytes    <= batch_bytes_next;
    end
  end

endmodule

@@ src/sticky_round_robin_partition_router.sv @@
// Sticky round-robin partition router: top level, config and sequencer.
// Requests are handled one at a time: in_stall is high from acceptance until the
// result of the 32-step radix-2 remainder unit is loaded into the output register.
// If the output stalls, the result waits in the divider and no request is taken.
// Reset (rst, synchronous): cursor and batch counters clear, config takes its
// reset values (batching on, 1000 msgs, 131072 bytes, 10 ms, 1 partition).
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sticky_round_robin_partition_router
  import srr_pkg::*;
#(
  parameter int unsigned MAX_PARTITIONS = 1024
) (
  input  logic                  clk,
  input  logic                  rst,
  // configuration write channel
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // request channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  has_key,
  input  logic [HASH_W-1:0]     key_hash,
  input  logic [LEN_W-1:0]      message_length,
  input  logic [TIME_W-1:0]     now_ms,
  // result channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [PART_W-1:0]     partition,
  output logic                  new_batch
);

  localparam int unsigned PART_CAP =
    (MAX_PARTITIONS < PART_CNT_MAX) ? MAX_PARTITIONS : PART_CNT_MAX;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_HOLD = 2'd2;

  logic [1:0] state, state_next;

  logic                  batching_enabled;
  logic [MSGS_W-1:0]     max_batch_messages;
  logic [LEN_W-1:0]      max_batch_bytes;
  logic [DELAY_W-1:0]    max_batch_delay_ms;
  logic [PART_CNT_W-1:0] num_partitions;
  cfg_t                  cfg;

  logic                  accept;
  logic [DIVIDEND_W-1:0] dividend;
  logic                  fresh;
  logic                  fresh_pend;
  logic                  div_busy;
  logic                  div_done;
  logic [PART_CNT_W-1:0] div_rem;
  logic                  out_free;
  logic                  load_out;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      batching_enabled   <= 1'b1;
      max_batch_messages <= MSGS_W'(1000);
      max_batch_bytes    <= LEN_W'(131072);
      max_batch_delay_ms <= DELAY_W'(10);
      num_partitions     <= PART_CNT_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_BATCHING_ENABLED:   batching_enabled   <= cfg_data[0];
        REG_MAX_BATCH_MESSAGES: max_batch_messages <= cfg_data[MSGS_W-1:0];
        REG_MAX_BATCH_BYTES:    max_batch_bytes    <= cfg_data[LEN_W-1:0];
        REG_MAX_BATCH_DELAY_MS: max_batch_delay_ms <= cfg_data[DELAY_W-1:0];
        REG_NUM_PARTITIONS:     num_partitions     <= cfg_data[PART_CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // effective partition count: zero means one, clamp to the supported maximum
  always_comb begin
    cfg.batching_enabled   = batching_enabled;
    cfg.max_batch_messages = max_batch_messages;
    cfg.max_batch_bytes    = max_batch_bytes;
    cfg.max_batch_delay_ms = max_batch_delay_ms;
    if (num_partitions == '0) begin
      cfg.n_eff = PART_CNT_W'(1);
    end else if (32'(num_partitions) > PART_CAP) begin
      cfg.n_eff = PART_CNT_W'(PART_CAP);
    end else begin
      cfg.n_eff = num_partitions;
    end
  end

  // sequencer
  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign load_out = ((state == ST_RUN) && div_done && out_free) ||
                    ((state == ST_HOLD) && out_free);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (accept) state_next = ST_RUN;
      ST_RUN: begin
        if (div_done) state_next = out_free ? ST_IDLE : ST_HOLD;
      end
      ST_HOLD: if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      fresh_pend <= fresh;
    end
    if (load_out) begin
      partition <= div_rem[PART_W-1:0];
      new_batch <= fresh_pend;
    end
  end

  srr_batch u_batch (
    .clk            (clk),
    .rst            (rst),
    .accept         (accept),
    .cfg            (cfg),
    .has_key        (has_key),
    .key_hash       (key_hash),
    .message_length (message_length),
    .now_ms         (now_ms),
    .dividend       (dividend),
    .fresh          (fresh)
  );

  srr_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (accept),
    .dividend (dividend),
    .divisor  (cfg.n_eff),
    .busy     (div_busy),
    .done     (div_done),
    .rem      (div_rem)
  );

  `SRR_ASSERT_IMPL(a_stall_while_dividing, div_busy, in_stall)
  `SRR_ASSERT_NEXT(a_accept_starts_div, accept, div_busy && (state == ST_RUN))

endmodule

@@ dv/tb_top.sv @@
// Self-checking testbench for the sticky round-robin partition router.
`timescale 1ns / 1ps

module tb_top;
  import srr_pkg::*;

  localparam int unsigned TB_MAX_PARTS     = 1024;
  localparam int unsigned NUM_PHASES       = 8;
  localparam int unsigned ITEMS_PER_PHASE  = 154;
  localparam int unsigned DRAIN_CYCLES     = 40;
  localparam int unsigned MAX_PRINTED_ERRS = 40;
  // Index with no register behind it; writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  typedef struct packed {
    logic              has_key;
    logic [HASH_W-1:0] key_hash;
    logic [LEN_W-1:0]  len;
    logic [TIME_W-1:0] now;
  } req_t;

  typedef struct packed {
    logic [PART_W-1:0] partition;
    logic              new_batch;
  } route_t;

  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e             kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    req_t                  req;
    logic                  typed;
    route_t                want;
  } row_t;

  // Clock and reset
  logic clk = 1'b0;
  logic rst = 1'b1;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // DUT ports
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  has_key = 1'b0;
  logic [HASH_W-1:0]     key_hash = '0;
  logic [LEN_W-1:0]      message_length = '0;
  logic [TIME_W-1:0]     now_ms = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [PART_W-1:0]     partition;
  logic                  new_batch;

  sticky_round_robin_partition_router #(
    .MAX_PARTITIONS(TB_MAX_PARTS)
  ) u_dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .has_key        (has_key),
    .key_hash       (key_hash),
    .message_length (message_length),
    .now_ms         (now_ms),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .partition      (partition),
    .new_batch      (new_batch)
  );

  // Predictor copy of the configuration, at reset values
  logic                  batch_mode     = 1'b1;
  logic [MSGS_W-1:0]     msg_limit      = 16'd1000;
  logic [LEN_W-1:0]      byte_limit     = 24'd131072;
  logic [DELAY_W-1:0]    delay_limit    = 16'd10;
  logic [PART_CNT_W-1:0] part_count_reg = 11'd1;

  // Predictor copy of the routing state
  logic [31:0]       rr_cursor      = '0;
  logic [TIME_W-1:0] switch_time    = '0;
  logic [MSGS_W-1:0] msgs_in_batch  = '0;
  logic [LEN_W-1:0]  bytes_in_batch = '0;

  route_t      pending_routes[$];
  row_t        plan[$];
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned err_count      = 0;
  int unsigned sent_cnt       = 0;
  int unsigned keyed_cnt      = 0;
  int unsigned checked_cnt    = 0;
  int unsigned switch_cnt     = 0;

  task automatic report_mismatch(input string what, input longint got, input longint want);
    err_count++;
    if (err_count <= MAX_PRINTED_ERRS) begin
      $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    end
  endtask

  // Partition choice for one request; advances the cursor and batch counters
  function automatic route_t route_request(input req_t r);
    route_t                res;
    logic [PART_CNT_W-1:0] n;
    logic [31:0]           rem;
    logic [TIME_W-1:0]     elapsed;
    logic [LEN_W:0]        byte_sum;
    res = '0;
    rem = '0;
    n = part_count_reg;
    if (n == '0) begin
      n = PART_CNT_W'(1);
    end else if (n > PART_CNT_W'(TB_MAX_PARTS)) begin
      n = PART_CNT_W'(TB_MAX_PARTS);
    end
    if (n == PART_CNT_W'(1)) begin
      // one partition: answer 0, nothing moves
    end else if (r.has_key) begin
      rem = {1'b0, r.key_hash} % {21'd0, n};
    end else if (!batch_mode) begin
      rem = rr_cursor % {21'd0, n};
      rr_cursor = rr_cursor + 32'd1;
    end else begin
      elapsed  = r.now - switch_time;  // wraps at 48 bits
      byte_sum = {1'b0, bytes_in_batch} + {1'b0, r.len};
      if (msgs_in_batch >= msg_limit || byte_sum >= {1'b0, byte_limit} ||
          elapsed >= {32'd0, delay_limit}) begin
        rr_cursor      = rr_cursor + 32'd1;
        switch_time    = r.now;
        bytes_in_batch = r.len;
        msgs_in_batch  = MSGS_W'(1);
        res.new_batch  = 1'b1;
      end else begin
        msgs_in_batch  = msgs_in_batch + MSGS_W'(1);
        bytes_in_batch = byte_sum[LEN_W-1:0];
      end
      rem = rr_cursor % {21'd0, n};
    end
    res.partition = rem[PART_W-1:0];
    return res;
  endfunction

  function automatic row_t req_row(input logic k, input logic [HASH_W-1:0] h,
                                   input logic [LEN_W-1:0] l, input logic [TIME_W-1:0] t,
                                   input logic typed, input logic [PART_W-1:0] p,
                                   input logic nb);
    row_t row;
    row = '0;
    row.kind  = ROW_REQ;
    row.req   = '{k, h, l, t};
    row.typed = typed;
    row.want  = '{p, nb};
    return row;
  endfunction

  function automatic row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                   input logic [CFG_DATA_W-1:0] data);
    row_t row;
    row = '0;
    row.kind = ROW_CFG;
    row.idx  = idx;
    row.data = data;
    return row;
  endfunction

  // Register write; leaves cfg_valid high for a write that may follow at once
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_BATCHING_ENABLED:   batch_mode     = data[0];
      REG_MAX_BATCH_MESSAGES: msg_limit      = data[MSGS_W-1:0];
      REG_MAX_BATCH_BYTES:    byte_limit     = data[LEN_W-1:0];
      REG_MAX_BATCH_DELAY_MS: delay_limit    = data[DELAY_W-1:0];
      REG_NUM_PARTITIONS:     part_count_reg = data[PART_CNT_W-1:0];
      default: ;
    endcase
  endtask

  // Drop the request valid and wait until every pending route has come back
  task automatic wait_all_routed();
    if (in_valid) in_valid <= 1'b0;
    while (pending_routes.size() != 0) @(posedge clk);
  endtask

  // One request: optional idle gap, then hold until accepted
  task automatic send_req(input req_t r, input logic typed, input route_t typed_want);
    route_t want;
    if (cfg_valid) cfg_valid <= 1'b0;
    if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      if (in_valid) in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_valid       <= 1'b1;
    has_key        <= r.has_key;
    key_hash       <= r.key_hash;
    message_length <= r.len;
    now_ms         <= r.now;
    do @(posedge clk); while (in_stall);
    want = route_request(r);
    if (typed) want = typed_want;
    pending_routes.push_back(want);
    sent_cnt++;
    if (r.has_key) keyed_cnt++;
  endtask

  // Receiver stall
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  // Result check against the oldest pending route
  always @(posedge clk) begin : result_check
    route_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_routes.size() == 0) begin
        report_mismatch("result with no request pending", partition, 0);
      end else begin
        want = pending_routes.pop_front();
        checked_cnt++;
        if (want.new_batch) switch_cnt++;
        if (partition !== want.partition) begin
          report_mismatch("partition", partition, want.partition);
        end
        if (new_batch !== want.new_batch) begin
          report_mismatch("new_batch", new_batch, want.new_batch);
        end
      end
    end
  end

  initial begin : stimulus
    req_t                  r;
    route_t                none;
    logic [63:0]           rnd;
    logic [TIME_W-1:0]     clock_ms;
    int unsigned           pick;
    int unsigned           phase;
    int unsigned           i;
    logic [CFG_DATA_W-1:0] val;

    none = '0;

    // Directed table, starting from the reset configuration (one partition)
    plan.push_back(req_row(1'b1, 31'h7FFF_FFFF, 24'hFF_FFFF, 48'hFFFF_FFFF_FFFF, 1'b1, 10'd0, 1'b0));
    plan.push_back(req_row(1'b0, 31'h0, 24'h0, 48'h0, 1'b1, 10'd0, 1'b0));
    // zero partition count acts as one partition
    plan.push_back(cfg_row(REG_NUM_PARTITIONS, 24'd0));
    plan.push_back(req_row(1'b0, 31'h5555_5555, 24'd123, 48'd100, 1'b1, 10'd0, 1'b0));
    // count above the maximum saturates to 1024
    plan.push_back(cfg_row(REG_NUM_PARTITIONS, 24'd2047));
    plan.push_back(req_row(1'b1, 31'h7FFF_FFFF, 24'd5, 48'd0, 1'b1, 10'd1023, 1'b0));
    plan.push_back(req_row(1'b1, 31'h0, 24'd5, 48'd0, 1'b1, 10'd0, 1'b0));
    plan.push_back(req_row(1'b1, 31'h2AAA_AAAA, 24'd5, 48'd0, 1'b0, 10'd0, 1'b0));
    // sticky batching: under limits, delay limit, byte limit
    plan.push_back(req_row(1'b0, 31'h0, 24'd0, 48'd5, 1'b0, 10'd0, 1'b0));
    plan.push_back(req_row(1'b0, 31'h0, 24'd0, 48'd10, 1'b0, 10'd0, 1'b0));
    plan.push_back(req_row(1'b0, 31'h0, 24'hFF_FFFF, 48'd11, 1'b0, 10'd0, 1'b0));
    // time counter wrap: small elapsed across the wrap, then a huge one
    plan.push_back(req_row(1'b0, 31'h0, 24'd1, 48'hFFFF_FFFF_FFFF, 1'b0, 10'd0, 1'b0));
    plan.push_back(req_row(1'b0, 31'h0, 24'd1, 48'd3, 1'b0, 10'd0, 1'b0));
    plan.push_back(req_row(1'b0, 31'h0, 24'd1, 48'hFFFF_FFFF_FFF0, 1'b0, 10'd0, 1'b0));
    // zero message limit switches every time
    plan.push_back(cfg_row(REG_MAX_BATCH_MESSAGES, 24'd0));
    plan.push_back(req_row(1'b0, 31'h0, 24'd0, 48'hFFFF_FFFF_FFF1, 1'b0, 10'd0, 1'b0));
    // all limits at their top; byte sum reaches the limit exactly
    plan.push_back(cfg_row(REG_MAX_BATCH_MESSAGES, 24'd65535));
    plan.push_back(cfg_row(REG_MAX_BATCH_BYTES, 24'hFF_FFFF));
    plan.push_back(cfg_row(REG_MAX_BATCH_DELAY_MS, 24'd65535));
    plan.push_back(req_row(1'b0, 31'h0, 24'd0, 48'hFFFF_FFFF_FFF2, 1'b0, 10'd0, 1'b0));
    plan.push_back(req_row(1'b0, 31'h0, 24'hFF_FFFE, 48'hFFFF_FFFF_FFF3, 1'b0, 10'd0, 1'b0));
    plan.push_back(req_row(1'b0, 31'h0, 24'd1, 48'hFFFF_FFFF_FFF4, 1'b0, 10'd0, 1'b0));
    // zero byte limit, then zero delay limit
    plan.push_back(cfg_row(REG_MAX_BATCH_BYTES, 24'd0));
    plan.push_back(req_row(1'b0, 31'h0, 24'd0, 48'hFFFF_FFFF_FFF5, 1'b0, 10'd0, 1'b0));
    plan.push_back(cfg_row(REG_MAX_BATCH_BYTES, 24'hFF_FFFF));
    plan.push_back(cfg_row(REG_MAX_BATCH_DELAY_MS, 24'd0));
    plan.push_back(req_row(1'b0, 31'h0, 24'd7, 48'hFFFF_FFFF_FFF5, 1'b0, 10'd0, 1'b0));
    // plain round-robin, keyed request in between
    plan.push_back(cfg_row(REG_BATCHING_ENABLED, 24'd0));
    plan.push_back(req_row(1'b0, 31'h0, 24'd9, 48'd20, 1'b0, 10'd0, 1'b0));
    plan.push_back(req_row(1'b0, 31'h0, 24'd9, 48'd20, 1'b0, 10'd0, 1'b0));
    plan.push_back(req_row(1'b1, 31'h0000_0401, 24'd9, 48'd20, 1'b0, 10'd0, 1'b0));
    plan.push_back(req_row(1'b0, 31'h0, 24'd9, 48'd20, 1'b0, 10'd0, 1'b0));
    // write to an unmapped index is dropped
    plan.push_back(cfg_row(REG_UNUSED, 24'hFF_FFFF));
    plan.push_back(cfg_row(REG_NUM_PARTITIONS, 24'd1025));
    plan.push_back(req_row(1'b0, 31'h0, 24'd9, 48'd20, 1'b0, 10'd0, 1'b0));
    plan.push_back(cfg_row(REG_NUM_PARTITIONS, 24'd3));
    plan.push_back(req_row(1'b0, 31'h0, 24'd9, 48'd20, 1'b0, 10'd0, 1'b0));
    plan.push_back(req_row(1'b0, 31'h0, 24'd9, 48'd20, 1'b0, 10'd0, 1'b0));

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[k]) begin
      if (plan[k].kind == ROW_CFG) begin
        wait_all_routed();
        write_reg(plan[k].idx, plan[k].data);
      end else begin
        send_req(plan[k].req, plan[k].typed, plan[k].want);
      end
    end

    // Random phases, each with its own configuration and idle profile
    for (phase = 0; phase < NUM_PHASES; phase++) begin
      wait_all_routed();
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct <= 0;  end
        1: begin send_idle_pct = 86; recv_stall_pct <= 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct <= 86; end
        default: begin send_idle_pct = 12; recv_stall_pct <= 12; end
      endcase

      write_reg(REG_BATCHING_ENABLED, (phase % 3 == 2) ? 24'd0 : 24'd1);

      case ($urandom_range(0, 5))
        0: pick = $urandom_range(0, 1);
        1: pick = 2;
        2: pick = $urandom_range(3, 16);
        3: pick = $urandom_range(17, 1024);
        4: pick = $urandom_range(1025, 2047);
        default: pick = TB_MAX_PARTS;
      endcase
      write_reg(REG_NUM_PARTITIONS, CFG_DATA_W'(pick));

      case ($urandom_range(0, 3))
        0: val = '0;
        1: val = CFG_DATA_W'($urandom_range(1, 8));
        2: val = CFG_DATA_W'($urandom_range(9, 200));
        default: val = 24'd65535;
      endcase
      write_reg(REG_MAX_BATCH_MESSAGES, val);

      case ($urandom_range(0, 3))
        0: val = '0;
        1: val = CFG_DATA_W'($urandom_range(1, 20000));
        2: val = CFG_DATA_W'($urandom_range(0, 24'hFF_FFFF));
        default: val = 24'hFF_FFFF;
      endcase
      write_reg(REG_MAX_BATCH_BYTES, val);

      case ($urandom_range(0, 3))
        0: val = '0;
        1: val = CFG_DATA_W'($urandom_range(1, 30));
        2: val = CFG_DATA_W'($urandom_range(0, 65535));
        default: val = 24'd65535;
      endcase
      write_reg(REG_MAX_BATCH_DELAY_MS, val);

      if ($urandom_range(0, 3) == 0) begin
        write_reg(CFG_IDX_W'($urandom_range(5, 7)), CFG_DATA_W'($urandom_range(0, 24'hFF_FFFF)));
      end

      // start time: zero, just below the wrap, or anywhere
      rnd = {$urandom, $urandom};
      case ($urandom_range(0, 3))
        0: clock_ms = '0;
        1: clock_ms = 48'hFFFF_FFFF_FFFF - TIME_W'($urandom_range(0, 300));
        default: clock_ms = rnd[TIME_W-1:0];
      endcase

      for (i = 0; i < ITEMS_PER_PHASE; i++) begin
        // hold off mid-phase until the block has emptied
        if (i == ITEMS_PER_PHASE / 2) wait_all_routed();
        rnd = {$urandom, $urandom};
        r.has_key  = ($urandom_range(0, 3) == 0);
        r.key_hash = rnd[HASH_W-1:0];
        case ($urandom_range(0, 19))
          0: r.len = '0;
          1: r.len = '1;
          2, 3, 4: r.len = rnd[63:40];
          default: r.len = LEN_W'($urandom_range(0, 4095));
        endcase
        rnd = {$urandom, $urandom};
        if ($urandom_range(0, 49) == 0) begin
          clock_ms = rnd[TIME_W-1:0];
        end else begin
          clock_ms = clock_ms + TIME_W'($urandom_range(0, 4));
        end
        r.now = clock_ms;
        send_req(r, 1'b0, none);
      end
    end

    // Let everything come back, then watch a little longer for strays
    wait_all_routed();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_routes.size() != 0) begin
      report_mismatch("results still pending at end", pending_routes.size(), 0);
    end

    $display("Routed %0d requests (%0d keyed) through %0d random configuration phases,",
             sent_cnt, keyed_cnt, NUM_PHASES);
    $display("%0d results checked, %0d of them opening a new batch, %0d mismatches.",
             checked_cnt, switch_cnt, err_count);
    if (err_count == 0) begin
      $display("[sticky_round_robin_partition_router] OK");
    end else begin
      $display("[sticky_round_robin_partition_router] ERROR");
    end
    $finish;
  end

  // Watchdog
  initial begin : watchdog
    #20_000_000;
    $display("[sticky_round_robin_partition_router] ERROR");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+src
src/srr_pkg.sv
src/srr_div.sv
src/srr_batch.sv
src/sticky_round_robin_partition_router.sv
dv/tb_top.sv
